@@ hw/rtl/prat_pkg.sv @@
`default_nettype none
package prat_pkg;

  typedef enum logic [1:0] {
    OP_ACT       = 2'd0,
    OP_MIT       = 2'd1,
    OP_CLR_ALERT = 2'd2,
    OP_CLR_ALL   = 2'd3
  } op_t;

  localparam logic [1:0] CFG_THRESHOLD = 2'd0;
  localparam logic [1:0] CFG_DELAY     = 2'd1;
  localparam logic [1:0] CFG_QLIMIT    = 2'd2;

  localparam logic [15:0] THRESHOLD_RST = 16'd128;
  localparam logic [15:0] DELAY_RST     = 16'd0;
  localparam logic [4:0]  QLIMIT_RST    = 5'd16;

  typedef enum logic [1:0] {
    SCAN_MATCH = 2'd0,
    SCAN_LOW   = 2'd1,
    SCAN_TOP   = 2'd2
  } scan_mode_t;

  typedef enum logic [4:0] {
    ST_INIT,
    ST_IDLE,
    ST_WIPE,
    ST_RC_RUN,
    ST_RC_TAIL,
    ST_A_RD,
    ST_A_LOAD,
    ST_A_WB,
    ST_P_SCAN,
    ST_P_WRITE,
    ST_P_CHK,
    ST_P_LSCAN,
    ST_P_DRD,
    ST_P_DWR,
    ST_M_TSCAN,
    ST_M_DRD,
    ST_M_DWR,
    ST_M_RD,
    ST_M_LOAD,
    ST_M_WB,
    ST_N_SEL,
    ST_N_RD,
    ST_N_LOAD,
    ST_N_WB,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic       accept;
    logic       cfg_we;
    logic       clr_start;
    logic       clr_step;
    logic       rc_start;
    logic       rc_step;
    logic       row_rd;
    logic       cnt_load;
    logic       mit_load;
    logic       note_wb;
    logic       wb_zero;
    logic       act_count;
    logic       alert_clr;
    logic       scan_start;
    logic       scan_run;
    scan_mode_t scan_mode;
    logic       q_write;
    logic       drop_rd;
    logic       drop_wr;
    logic       mit_take;
    logic       nb_start;
    logic       nb_next;
    logic       nb_take;
    logic       fin;
  } dp_cmd_t;

  typedef struct packed {
    logic fill_zero;
    logic over_lim;
    logic scan_done;
    logic sweep_last;
    logic nb_ok;
    logic nb_last;
    logic row_ok;
  } dp_sts_t;

endpackage
`default_nettype wire

@@ hw/rtl/prat_ctrl.sv @@
`default_nettype none
module prat_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [1:0]        operation,
  input  logic              cfg_valid,
  input  logic [1:0]        cfg_index,
  input  prat_pkg::dp_sts_t sts,
  output prat_pkg::dp_cmd_t cmd,
  output logic              busy,
  output logic              cfg_ready
);
  import prat_pkg::*;

  state_t state;
  state_t state_next;
  logic   is_mit;
  op_t    op;

  assign op        = op_t'(operation);
  assign busy      = (state != ST_IDLE);
  assign cfg_ready = (state == ST_IDLE) && !start;

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_INIT;
      is_mit <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.accept) begin
        is_mit <= (op == OP_MIT);
      end
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_INIT:    if (sts.sweep_last) state_next = ST_IDLE;
      ST_IDLE: begin
        if (start) begin
          case (op)
            OP_ACT:       state_next = sts.row_ok ? ST_A_RD : ST_FIN;
            OP_MIT:       state_next = sts.fill_zero ? ST_FIN : ST_M_TSCAN;
            OP_CLR_ALERT: state_next = ST_FIN;
            OP_CLR_ALL:   state_next = ST_WIPE;
            default:      state_next = ST_FIN;
          endcase
        end else if (cfg_valid && cfg_index == CFG_THRESHOLD) begin
          state_next = ST_RC_RUN;
        end
      end
      ST_WIPE:    if (sts.sweep_last) state_next = ST_FIN;
      ST_RC_RUN:  if (sts.sweep_last) state_next = ST_RC_TAIL;
      ST_RC_TAIL: state_next = ST_IDLE;
      ST_A_RD:    state_next = ST_A_LOAD;
      ST_A_LOAD:  state_next = sts.fill_zero ? ST_P_WRITE : ST_P_SCAN;
      ST_A_WB:    state_next = ST_FIN;
      ST_P_SCAN:  if (sts.scan_done) state_next = ST_P_WRITE;
      ST_P_WRITE: state_next = ST_P_CHK;
      ST_P_CHK: begin
        if (sts.over_lim) state_next = ST_P_LSCAN;
        else              state_next = is_mit ? ST_N_WB : ST_A_WB;
      end
      ST_P_LSCAN: if (sts.scan_done) state_next = ST_P_DRD;
      ST_P_DRD:   state_next = ST_P_DWR;
      ST_P_DWR:   state_next = is_mit ? ST_N_WB : ST_A_WB;
      ST_M_TSCAN: if (sts.scan_done) state_next = ST_M_DRD;
      ST_M_DRD:   state_next = ST_M_DWR;
      ST_M_DWR:   state_next = ST_M_RD;
      ST_M_RD:    state_next = ST_M_LOAD;
      ST_M_LOAD:  state_next = ST_M_WB;
      ST_M_WB:    state_next = ST_N_SEL;
      ST_N_SEL: begin
        if (sts.nb_ok)        state_next = ST_N_RD;
        else if (sts.nb_last) state_next = ST_FIN;
      end
      ST_N_RD:    state_next = ST_N_LOAD;
      ST_N_LOAD:  state_next = sts.fill_zero ? ST_P_WRITE : ST_P_SCAN;
      ST_N_WB:    state_next = sts.nb_last ? ST_FIN : ST_N_SEL;
      ST_FIN:     state_next = ST_IDLE;
      default:    state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd        = '0;
    cmd.accept = (state == ST_IDLE) && start;
    cmd.cfg_we = cfg_ready && cfg_valid;
    case (state)
      ST_INIT: cmd.clr_step = 1'b1;
      ST_IDLE: begin
        if (start) begin
          case (op)
            OP_ACT:       ;
            OP_MIT:       cmd.scan_start = !sts.fill_zero;
            OP_CLR_ALERT: cmd.alert_clr = 1'b1;
            OP_CLR_ALL:   cmd.clr_start = 1'b1;
            default:      ;
          endcase
        end else if (cfg_valid && cfg_index == CFG_THRESHOLD) begin
          cmd.rc_start = 1'b1;
        end
      end
      ST_WIPE:    cmd.clr_step = 1'b1;
      ST_RC_RUN:  cmd.rc_step = 1'b1;
      ST_RC_TAIL: ;
      ST_A_RD:    cmd.row_rd = 1'b1;
      ST_A_LOAD: begin
        cmd.cnt_load   = 1'b1;
        cmd.scan_start = 1'b1;
      end
      ST_A_WB: begin
        cmd.note_wb   = 1'b1;
        cmd.act_count = 1'b1;
      end
      ST_P_SCAN: begin
        cmd.scan_run  = 1'b1;
        cmd.scan_mode = SCAN_MATCH;
      end
      ST_P_WRITE: cmd.q_write = 1'b1;
      ST_P_CHK:   cmd.scan_start = sts.over_lim;
      ST_P_LSCAN: begin
        cmd.scan_run  = 1'b1;
        cmd.scan_mode = SCAN_LOW;
      end
      ST_P_DRD:   cmd.drop_rd = 1'b1;
      ST_P_DWR:   cmd.drop_wr = 1'b1;
      ST_M_TSCAN: begin
        cmd.scan_run  = 1'b1;
        cmd.scan_mode = SCAN_TOP;
      end
      ST_M_DRD: begin
        cmd.drop_rd  = 1'b1;
        cmd.mit_take = 1'b1;
      end
      ST_M_DWR:   cmd.drop_wr = 1'b1;
      ST_M_RD:    cmd.row_rd = 1'b1;
      ST_M_LOAD:  cmd.mit_load = 1'b1;
      ST_M_WB: begin
        cmd.note_wb  = 1'b1;
        cmd.wb_zero  = 1'b1;
        cmd.nb_start = 1'b1;
      end
      ST_N_SEL: begin
        cmd.nb_take = sts.nb_ok;
        cmd.nb_next = !sts.nb_ok && !sts.nb_last;
      end
      ST_N_RD:    cmd.row_rd = 1'b1;
      ST_N_LOAD: begin
        cmd.cnt_load   = 1'b1;
        cmd.scan_start = 1'b1;
      end
      ST_N_WB: begin
        cmd.note_wb = 1'b1;
        cmd.nb_next = !sts.nb_last;
      end
      ST_FIN:     cmd.fin = 1'b1;
      default:    ;
    endcase
  end

endmodule
`default_nettype wire

@@ hw/rtl/prat_dp.sv @@
`default_nettype none
module prat_dp #(
  parameter int ROW_COUNT   = 65536,
  parameter int QUEUE_DEPTH = 16,
  parameter int COUNT_BITS  = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  prat_pkg::dp_cmd_t cmd,
  output prat_pkg::dp_sts_t sts,
  input  logic [15:0]       row,
  input  logic [1:0]        cfg_index,
  input  logic [15:0]       cfg_data,
  output logic              done,
  output logic [15:0]       mitigated_row,
  output logic              mitigated_valid,
  output logic              alert,
  output logic [15:0]       global_peak,
  output logic [16:0]       rows_over_threshold,
  output logic [31:0]       activations_total
);
  import prat_pkg::*;

  localparam int ROW_AW = $clog2(ROW_COUNT);
  localparam int QW     = $clog2(QUEUE_DEPTH + 1);
  localparam int FW     = $clog2(QUEUE_DEPTH + 2);
  localparam int CB     = COUNT_BITS;
  localparam int QEW    = CB + ROW_AW;

  function automatic logic above(input logic [CB-1:0] ca, input logic [ROW_AW-1:0] ra,
                                 input logic [CB-1:0] cb, input logic [ROW_AW-1:0] rb);
    logic r;
    if (ca != cb) r = ca > cb;
    else          r = ra < rb;
    return r;
  endfunction

  logic [15:0] thr;
  logic [15:0] delay;
  logic [4:0]  qlimit;

  logic [ROW_AW-1:0] cur_row;
  logic [ROW_AW-1:0] mit_row;
  logic [CB-1:0]     cur_cnt;
  logic [CB-1:0]     cur_peak;
  logic              mit_valid;
  logic              alert_on;
  logic [31:0]       acts;
  logic [31:0]       serviced;
  logic [CB-1:0]     peak_seen;
  logic [16:0]       over;

  // row counter/peak store
  logic [2*CB-1:0]   rmem [ROW_COUNT];
  logic [2*CB-1:0]   r_q;
  logic              r_rd_en;
  logic [ROW_AW-1:0] r_rd_addr;
  logic              r_we;
  logic [ROW_AW-1:0] r_wr_addr;
  logic [2*CB-1:0]   r_wr_data;
  logic [CB-1:0]     r_cnt;
  logic [CB-1:0]     r_peak;
  logic [ROW_AW-1:0] sweep_addr;
  logic              rc_pend;

  // queue store
  logic [QEW-1:0]    qmem [QUEUE_DEPTH+1];
  logic [QEW-1:0]    q_q;
  logic              q_rd_en;
  logic [QW-1:0]     q_rd_addr;
  logic              q_we;
  logic [QW-1:0]     q_wr_addr;
  logic [QEW-1:0]    q_wr_data;
  logic [CB-1:0]     q_cnt;
  logic [ROW_AW-1:0] q_row;
  logic [FW-1:0]     fill;
  logic [FW-1:0]     fill_m1;
  logic [7:0]        lim;

  logic [FW-1:0]     scan_k;
  logic [FW-1:0]     pend_k;
  logic              scan_pend;
  logic              scan_issue;
  logic              found;
  logic [QW-1:0]     found_idx;
  logic [QW-1:0]     best_idx;
  logic [CB-1:0]     best_cnt;
  logic [ROW_AW-1:0] best_row;
  logic              take_best;

  logic [1:0]        nb_j;
  logic [ROW_AW+1:0] mr_ext;
  logic [ROW_AW+1:0] nb_cand;
  logic              nb_ok;

  logic [CB-1:0]     new_peak;
  logic              crosses;

  assign r_cnt   = r_q[CB-1:0];
  assign r_peak  = r_q[2*CB-1:CB];
  assign q_cnt   = q_q[ROW_AW +: CB];
  assign q_row   = q_q[ROW_AW-1:0];
  assign fill_m1 = fill - FW'(1);
  assign lim     = (8'(qlimit) < 8'(QUEUE_DEPTH)) ? 8'(qlimit) : 8'(QUEUE_DEPTH);

  assign new_peak = (cur_cnt > cur_peak) ? cur_cnt : cur_peak;
  assign crosses  = (cur_cnt > cur_peak) && (32'(cur_peak) <= 32'(thr)) &&
                    (32'(cur_cnt) > 32'(thr));

  assign r_rd_en   = cmd.row_rd || cmd.rc_step;
  assign r_rd_addr = cmd.rc_step ? sweep_addr : cur_row;
  assign r_we      = cmd.clr_step || cmd.note_wb;
  assign r_wr_addr = cmd.clr_step ? sweep_addr : cur_row;
  assign r_wr_data = cmd.clr_step ? '0 : {new_peak, (cmd.wb_zero ? {CB{1'b0}} : cur_cnt)};

  always_ff @(posedge clk) begin
    if (r_rd_en) r_q <= rmem[r_rd_addr];
    if (r_we)    rmem[r_wr_addr] <= r_wr_data;
  end

  assign scan_issue = cmd.scan_run && (scan_k < fill);
  assign q_rd_en    = cmd.drop_rd || scan_issue;
  assign q_rd_addr  = cmd.drop_rd ? fill_m1[QW-1:0] : scan_k[QW-1:0];
  assign q_we       = cmd.q_write || cmd.drop_wr;
  assign q_wr_addr  = cmd.q_write ? (found ? found_idx : fill[QW-1:0]) : best_idx;
  assign q_wr_data  = cmd.q_write ? {cur_cnt, cur_row} : q_q;

  always_ff @(posedge clk) begin
    if (q_rd_en) q_q <= qmem[q_rd_addr];
    if (q_we)    qmem[q_wr_addr] <= q_wr_data;
  end

  always_comb begin
    case (cmd.scan_mode)
      SCAN_TOP: take_best = (pend_k == '0) || above(q_cnt, q_row, best_cnt, best_row);
      SCAN_LOW: take_best = (pend_k == '0) || above(best_cnt, best_row, q_cnt, q_row);
      default:  take_best = 1'b0;
    endcase
  end

  assign mr_ext = (ROW_AW+2)'(mit_row);
  always_comb begin
    case (nb_j)
      2'd0: begin
        nb_cand = mr_ext - (ROW_AW+2)'(2);
        nb_ok   = mr_ext >= (ROW_AW+2)'(2);
      end
      2'd1: begin
        nb_cand = mr_ext - (ROW_AW+2)'(1);
        nb_ok   = mr_ext >= (ROW_AW+2)'(1);
      end
      2'd2: begin
        nb_cand = mr_ext + (ROW_AW+2)'(1);
        nb_ok   = nb_cand < (ROW_AW+2)'(ROW_COUNT);
      end
      default: begin
        nb_cand = mr_ext + (ROW_AW+2)'(2);
        nb_ok   = nb_cand < (ROW_AW+2)'(ROW_COUNT);
      end
    endcase
  end

  assign sts.fill_zero  = (fill == '0);
  assign sts.over_lim   = 8'(fill) > lim;
  assign sts.scan_done  = scan_pend && (pend_k == fill_m1);
  assign sts.sweep_last = (sweep_addr == ROW_AW'(ROW_COUNT - 1));
  assign sts.nb_ok      = nb_ok;
  assign sts.nb_last    = (nb_j == 2'd3);
  assign sts.row_ok     = 32'(row) < 32'(ROW_COUNT);

  always_ff @(posedge clk) begin
    if (rst) begin
      thr        <= THRESHOLD_RST;
      delay      <= DELAY_RST;
      qlimit     <= QLIMIT_RST;
      fill       <= '0;
      alert_on   <= 1'b0;
      acts       <= 32'(DELAY_RST);
      serviced   <= '0;
      peak_seen  <= '0;
      over       <= '0;
      sweep_addr <= '0;
      rc_pend    <= 1'b0;
      scan_pend  <= 1'b0;
      scan_k     <= '0;
      found      <= 1'b0;
      nb_j       <= '0;
      mit_valid  <= 1'b0;
      done       <= 1'b0;
    end else begin
      rc_pend   <= cmd.rc_step;
      scan_pend <= scan_issue;
      done      <= cmd.fin;

      if (cmd.cfg_we) begin
        case (cfg_index)
          CFG_THRESHOLD: thr    <= cfg_data;
          CFG_DELAY:     delay  <= cfg_data;
          CFG_QLIMIT:    qlimit <= cfg_data[4:0];
          default:       ;
        endcase
      end

      if (cmd.clr_start || cmd.rc_start) sweep_addr <= '0;
      else if (cmd.clr_step || cmd.rc_step) sweep_addr <= sweep_addr + ROW_AW'(1);

      if (cmd.clr_start) begin
        fill      <= '0;
        alert_on  <= 1'b0;
        acts      <= '0;
        serviced  <= '0;
        peak_seen <= '0;
        over      <= '0;
      end else begin
        if (cmd.q_write && !found) fill <= fill + FW'(1);
        else if (cmd.drop_wr)      fill <= fill_m1;

        if (cmd.alert_clr) alert_on <= 1'b0;
        else if (cmd.act_count && 32'(cur_cnt) >= 32'(thr) && acts >= 32'(delay))
          alert_on <= 1'b1;

        if (cmd.act_count) begin
          if (acts != '1)     acts     <= acts + 32'd1;
          if (serviced != '1) serviced <= serviced + 32'd1;
        end

        if (cmd.note_wb && cur_cnt > peak_seen) peak_seen <= cur_cnt;

        if (cmd.rc_start) over <= '0;
        else if (rc_pend && 32'(r_peak) > 32'(thr) && over != '1) over <= over + 17'd1;
        else if (cmd.note_wb && crosses && over != '1) over <= over + 17'd1;
      end

      if (cmd.scan_start) scan_k <= '0;
      else if (scan_issue) scan_k <= scan_k + FW'(1);

      if (cmd.scan_start) found <= 1'b0;
      else if (scan_pend && cmd.scan_mode == SCAN_MATCH && q_row == cur_row) found <= 1'b1;

      if (cmd.nb_start) nb_j <= '0;
      else if (cmd.nb_next) nb_j <= nb_j + 2'd1;

      if (cmd.accept) mit_valid <= 1'b0;
      else if (cmd.mit_take) mit_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    pend_k <= scan_k;
    if (scan_pend && cmd.scan_mode == SCAN_MATCH && q_row == cur_row) begin
      found_idx <= pend_k[QW-1:0];
    end
    if (scan_pend && take_best) begin
      best_idx <= pend_k[QW-1:0];
      best_cnt <= q_cnt;
      best_row <= q_row;
    end
    if (cmd.accept) cur_row <= ROW_AW'(row);
    else if (cmd.mit_take) cur_row <= best_row;
    else if (cmd.nb_take) cur_row <= nb_cand[ROW_AW-1:0];
    if (cmd.mit_take) mit_row <= best_row;
    if (cmd.cnt_load) begin
      cur_cnt  <= (r_cnt == '1) ? r_cnt : r_cnt + CB'(1);
      cur_peak <= r_peak;
    end else if (cmd.mit_load) begin
      cur_cnt  <= r_cnt;
      cur_peak <= r_peak;
    end
    if (cmd.fin) begin
      mitigated_row       <= mit_valid ? 16'(mit_row) : 16'd0;
      mitigated_valid     <= mit_valid;
      alert               <= alert_on;
      global_peak         <= 16'(peak_seen);
      rows_over_threshold <= over;
      activations_total   <= serviced;
    end
  end

endmodule
`default_nettype wire

@@ hw/rtl/per_row_activation_tracker.sv @@
// Per-row activation tracker with a bounded top-N mitigation queue.
// Command channel: an item (operation, row) is taken when start is high and
// busy is low. Operations: activate a row, mitigate the top queued row,
// clear the alert, clear everything.
// Result: every item gives one result, shown for one cycle with done high;
// the outputs then hold until the next result. The receiver cannot stall.
// Items are handled one at a time, by a state machine over one row store
// port and one queue store port:
//   clear alert, or activate of a row beyond the array: no store access
//   activate: reads and counts the row, scans the queue for it and writes
//   it in, plus a scan for the lowest entry and its drop on an eviction
//   mitigate: takes the top entry, if any, out of the queue and zeroes its
//   count, then counts and queues each neighbour, with its own evictions
//   clear all: the row store is zeroed one row a cycle
// Configuration: cfg_valid/cfg_ready with cfg_index and cfg_data, taken only
// when idle. A threshold write re-scans every row peak, with busy high.
// Reset: the row store is zeroed one row a cycle, with busy high;
// configuration writes wait until it ends.
`default_nettype none
module per_row_activation_tracker #(
  parameter int ROW_COUNT   = 65536,
  parameter int QUEUE_DEPTH = 16,
  parameter int COUNT_BITS  = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  operation,
  input  logic [15:0] row,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  output logic        done,
  output logic [15:0] mitigated_row,
  output logic        mitigated_valid,
  output logic        alert,
  output logic [15:0] global_peak,
  output logic [16:0] rows_over_threshold,
  output logic [31:0] activations_total
);
  import prat_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  prat_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .operation (operation),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .sts       (sts),
    .cmd       (cmd),
    .busy      (busy),
    .cfg_ready (cfg_ready)
  );

  prat_dp #(
    .ROW_COUNT   (ROW_COUNT),
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .COUNT_BITS  (COUNT_BITS)
  ) u_dp (
    .clk                 (clk),
    .rst                 (rst),
    .cmd                 (cmd),
    .sts                 (sts),
    .row                 (row),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data),
    .done                (done),
    .mitigated_row       (mitigated_row),
    .mitigated_valid     (mitigated_valid),
    .alert               (alert),
    .global_peak         (global_peak),
    .rows_over_threshold (rows_over_threshold),
    .activations_total   (activations_total)
  );

  a_item_starts_work: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("accepted item did not start work");

  a_cfg_only_idle: assert property (@(posedge clk) disable iff (rst)
    cfg_valid && cfg_ready |-> !busy && !start && !cmd.accept)
    else $error("configuration taken while not idle");

  a_done_after_work: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy) && !$past(done))
    else $error("result without preceding work");

endmodule
`default_nettype wire
